/* hdl/ikvt_pkg.sv */
package ikvt_pkg;

    localparam int POS_BITS = 16;
    localparam int FIELD_BITS = 16;

    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [FIELD_BITS-1:0] t_field;
    typedef logic [7:0] t_char;

    localparam t_pos POS_MAX = {POS_BITS{1'b1}};

    localparam t_char CH_NUL = 8'h00;
    localparam t_char CH_TAB = 8'h09;
    localparam t_char CH_LF = 8'h0A;
    localparam t_char CH_VT = 8'h0B;
    localparam t_char CH_FF = 8'h0C;
    localparam t_char CH_CR = 8'h0D;
    localparam t_char CH_SPACE = 8'h20;
    localparam t_char CH_SEMI = 8'h3B;
    localparam t_char CH_EQ = 8'h3D;
    localparam t_char CH_UNDER = 8'h5F;

    typedef enum logic [2:0] {
        MODE_JUNK,
        MODE_LINE_SKIP,
        MODE_KEY,
        MODE_BEFORE_EQ,
        MODE_AFTER_EQ,
        MODE_VALUE
    } t_mode;

    typedef struct packed {
        t_field key_start;
        t_field key_length;
        t_field value_start;
        t_field value_length;
        t_field value_trimmed_length;
    } t_result;

    function automatic logic is_blank(input t_char c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic logic is_eol(input t_char c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_space(input t_char c);
        return is_blank(c) || is_eol(c);
    endfunction

    function automatic logic is_alpha(input t_char c);
        return (c == CH_UNDER) || ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_digit(input t_char c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_term(input t_char c);
        return (c == CH_NUL) || (c == CH_SEMI) || is_eol(c);
    endfunction

    function automatic t_pos sat_inc(input t_pos v);
        return (v == POS_MAX) ? v : t_pos'(v + t_pos'(1));
    endfunction

    function automatic t_field to_field(input t_pos v);
        return FIELD_BITS'(v);
    endfunction

    function automatic t_mode junk_mode(input t_char c);
        t_mode m;
        if ((c == CH_NUL) || is_space(c)) begin
            m = MODE_JUNK;
        end else if (is_alpha(c)) begin
            m = MODE_KEY;
        end else begin
            m = MODE_LINE_SKIP;
        end
        return m;
    endfunction

    function automatic t_mode skip_mode(input t_char c);
        return ((c == CH_NUL) || is_eol(c)) ? MODE_JUNK : MODE_LINE_SKIP;
    endfunction

endpackage

/* hdl/ikvt_scan.sv */
module ikvt_scan (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  ikvt_pkg::t_char  i_byte,
    output logic             o_emit,
    output ikvt_pkg::t_result o_result
);

    ikvt_pkg::t_mode r_mode;
    ikvt_pkg::t_mode n_mode;
    ikvt_pkg::t_pos  r_pos;
    ikvt_pkg::t_pos  r_key_start;
    ikvt_pkg::t_pos  r_key_len;
    ikvt_pkg::t_pos  r_val_start;
    ikvt_pkg::t_pos  r_val_len;
    ikvt_pkg::t_pos  r_trim_len;

    logic key_load;
    logic key_inc;
    logic val_load;
    logic val_inc;
    logic emit;

    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            ikvt_pkg::MODE_KEY: begin
                if (ikvt_pkg::is_alpha(i_byte) || ikvt_pkg::is_digit(i_byte)) begin
                    n_mode = ikvt_pkg::MODE_KEY;
                end else if (ikvt_pkg::is_blank(i_byte)) begin
                    n_mode = ikvt_pkg::MODE_BEFORE_EQ;
                end else if (i_byte == ikvt_pkg::CH_EQ) begin
                    n_mode = ikvt_pkg::MODE_AFTER_EQ;
                end else begin
                    n_mode = ikvt_pkg::skip_mode(i_byte);
                end
            end
            ikvt_pkg::MODE_BEFORE_EQ: begin
                if (ikvt_pkg::is_blank(i_byte)) begin
                    n_mode = ikvt_pkg::MODE_BEFORE_EQ;
                end else if (i_byte == ikvt_pkg::CH_EQ) begin
                    n_mode = ikvt_pkg::MODE_AFTER_EQ;
                end else begin
                    n_mode = ikvt_pkg::skip_mode(i_byte);
                end
            end
            ikvt_pkg::MODE_AFTER_EQ: begin
                if (ikvt_pkg::is_blank(i_byte)) begin
                    n_mode = ikvt_pkg::MODE_AFTER_EQ;
                end else if (ikvt_pkg::is_term(i_byte)) begin
                    n_mode = ikvt_pkg::junk_mode(i_byte);
                end else begin
                    n_mode = ikvt_pkg::MODE_VALUE;
                end
            end
            ikvt_pkg::MODE_VALUE: begin
                if (ikvt_pkg::is_term(i_byte)) begin
                    n_mode = ikvt_pkg::junk_mode(i_byte);
                end else begin
                    n_mode = ikvt_pkg::MODE_VALUE;
                end
            end
            ikvt_pkg::MODE_LINE_SKIP: begin
                n_mode = ikvt_pkg::skip_mode(i_byte);
            end
            default: begin
                n_mode = ikvt_pkg::junk_mode(i_byte);
            end
        endcase
        if (i_byte == ikvt_pkg::CH_NUL) begin
            n_mode = ikvt_pkg::MODE_JUNK;
        end
    end

    always_comb begin
        key_load = 1'b0;
        key_inc  = 1'b0;
        val_load = 1'b0;
        val_inc  = 1'b0;
        emit     = 1'b0;
        unique case (r_mode)
            ikvt_pkg::MODE_KEY: begin
                key_inc = ikvt_pkg::is_alpha(i_byte) || ikvt_pkg::is_digit(i_byte);
            end
            ikvt_pkg::MODE_AFTER_EQ: begin
                val_load = !ikvt_pkg::is_blank(i_byte) && !ikvt_pkg::is_term(i_byte);
            end
            ikvt_pkg::MODE_VALUE: begin
                emit    = ikvt_pkg::is_term(i_byte);
                val_inc = !ikvt_pkg::is_term(i_byte);
            end
            ikvt_pkg::MODE_BEFORE_EQ, ikvt_pkg::MODE_LINE_SKIP: begin
                key_load = 1'b0;
            end
            default: begin
                key_load = ikvt_pkg::is_alpha(i_byte);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ikvt_pkg::MODE_JUNK;
            r_pos  <= '0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_pos  <= (i_byte == ikvt_pkg::CH_NUL) ? '0 : ikvt_pkg::sat_inc(r_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (key_load) begin
                r_key_start <= r_pos;
                r_key_len   <= ikvt_pkg::t_pos'(1);
            end else if (key_inc) begin
                r_key_len <= ikvt_pkg::sat_inc(r_key_len);
            end
            if (val_load) begin
                r_val_start <= r_pos;
                r_val_len   <= ikvt_pkg::t_pos'(1);
                r_trim_len  <= ikvt_pkg::t_pos'(1);
            end else if (val_inc) begin
                r_val_len <= ikvt_pkg::sat_inc(r_val_len);
                if (!ikvt_pkg::is_space(i_byte)) begin
                    r_trim_len <= ikvt_pkg::sat_inc(r_val_len);
                end
            end
        end
    end

    assign o_emit = emit;
    assign o_result.key_start = ikvt_pkg::to_field(r_key_start);
    assign o_result.key_length = ikvt_pkg::to_field(r_key_len);
    assign o_result.value_start = ikvt_pkg::to_field(r_val_start);
    assign o_result.value_length = ikvt_pkg::to_field(r_val_len);
    assign o_result.value_trimmed_length = ikvt_pkg::to_field(r_trim_len);

endmodule

/* hdl/ikvt_out_reg.sv */
module ikvt_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ikvt_pkg::t_result i_result,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output ikvt_pkg::t_result o_result
);

    logic              r_valid;
    ikvt_pkg::t_result r_result;

    assign o_room = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_room && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* hdl/ini_key_value_tokenizer.sv */
// A result enters the result register as the byte ending its value leaves the input register.
// Throughput: one byte per cycle; the input register and the result register are
// the only stages, and a byte waits in the input register only while it ends a value
// and the result register still holds an untaken result.
// Reset: synchronous and active low; the scanner returns to skipping and the offset to zero.
module ini_key_value_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_key_start,
    output logic [15:0] o_key_length,
    output logic [15:0] o_value_start,
    output logic [15:0] o_value_length,
    output logic [15:0] o_value_trimmed_length
);

    logic              r_in_valid;
    ikvt_pkg::t_char   r_in_byte;
    logic              step;
    logic              emit;
    logic              room;
    ikvt_pkg::t_result scan_result;
    ikvt_pkg::t_result out_result;

    assign step    = r_in_valid && (room || !emit);
    assign o_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_text_byte;
        end
    end

    ikvt_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_emit   (emit),
        .o_result (scan_result)
    );

    ikvt_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_in_valid && emit),
        .i_result (scan_result),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_key_start            = 16'(out_result.key_start);
    assign o_key_length           = 16'(out_result.key_length);
    assign o_value_start          = 16'(out_result.value_start);
    assign o_value_length         = 16'(out_result.value_length);
    assign o_value_trimmed_length = 16'(out_result.value_trimmed_length);

endmodule

/* hdl/ikvt_checker.sv */
module ikvt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_key_start,
    input logic [15:0] o_key_length,
    input logic [15:0] o_value_start,
    input logic [15:0] o_value_length,
    input logic [15:0] o_value_trimmed_length
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid right after reset.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("Input stalled while no result is pending.");

    a_lengths_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_key_length != 16'd0) && (o_value_trimmed_length != 16'd0)
            && (o_value_trimmed_length <= o_value_length))
        else $error("Result lengths are inconsistent.");

    a_value_after_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_value_start >= o_key_start))
        else $error("Value starts before its key.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_key_start) && $stable(o_key_length)
            && $stable(o_value_start) && $stable(o_value_length)
            && $stable(o_value_trimmed_length))
        else $error("Stalled result changed.");

endmodule

bind ini_key_value_tokenizer ikvt_checker u_ikvt_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .o_ready                (o_ready),
    .o_valid                (o_valid),
    .i_ready                (i_ready),
    .o_key_start            (o_key_start),
    .o_key_length           (o_key_length),
    .o_value_start          (o_value_start),
    .o_value_length         (o_value_length),
    .o_value_trimmed_length (o_value_trimmed_length)
);

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        ikvt_pkg::t_char   text;
        bit                fixed;
        ikvt_pkg::t_result want;
    } t_text_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_text_byte;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_key_start;
    logic [15:0] o_key_length;
    logic [15:0] o_value_start;
    logic [15:0] o_value_length;
    logic [15:0] o_value_trimmed_length;

    t_text_item        text_stream[$];
    ikvt_pkg::t_result pending_entries[$];
    int                fail_count = 0;
    int                entries_checked = 0;

    ikvt_pkg::t_mode scan_state = ikvt_pkg::MODE_JUNK;
    ikvt_pkg::t_pos  next_offset = '0;
    ikvt_pkg::t_pos  cur_key_start = '0;
    ikvt_pkg::t_pos  cur_key_len = '0;
    ikvt_pkg::t_pos  cur_val_start = '0;
    ikvt_pkg::t_pos  cur_val_len = '0;
    ikvt_pkg::t_pos  cur_trim_len = '0;

    ikvt_pkg::t_char blank_set[4] = '{ikvt_pkg::CH_SPACE, ikvt_pkg::CH_TAB,
                                      ikvt_pkg::CH_VT, ikvt_pkg::CH_FF};

    // Each row is one byte; rows that close an entry carry the entry typed in by hand.
    t_text_item dir_rows[27] = '{
        '{ikvt_pkg::CH_UNDER, 1'b0, '0},
        '{"9",                1'b0, '0},
        '{ikvt_pkg::CH_SPACE, 1'b0, '0},
        '{ikvt_pkg::CH_EQ,    1'b0, '0},
        '{ikvt_pkg::CH_TAB,   1'b0, '0},
        '{"Z",                1'b0, '0},
        '{ikvt_pkg::CH_FF,    1'b0, '0},
        '{ikvt_pkg::CH_SEMI,  1'b1, {16'd0, 16'd2, 16'd5, 16'd2, 16'd1}},
        '{"q",                1'b0, '0},
        '{ikvt_pkg::CH_LF,    1'b0, '0},
        '{"7",                1'b0, '0},
        '{ikvt_pkg::CH_CR,    1'b0, '0},
        '{"k",                1'b0, '0},
        '{ikvt_pkg::CH_EQ,    1'b0, '0},
        '{ikvt_pkg::CH_LF,    1'b0, '0},
        '{"a",                1'b0, '0},
        '{"!",                1'b0, '0},
        '{ikvt_pkg::CH_LF,    1'b0, '0},
        '{"b",                1'b0, '0},
        '{ikvt_pkg::CH_EQ,    1'b0, '0},
        '{8'hFF,              1'b0, '0},
        '{ikvt_pkg::CH_VT,    1'b0, '0},
        '{ikvt_pkg::CH_NUL,   1'b1, {16'd18, 16'd1, 16'd20, 16'd2, 16'd1}},
        '{"x",                1'b0, '0},
        '{ikvt_pkg::CH_EQ,    1'b0, '0},
        '{8'h80,              1'b0, '0},
        '{ikvt_pkg::CH_CR,    1'b1, {16'd0, 16'd1, 16'd2, 16'd1, 16'd1}}
    };

    ini_key_value_tokenizer dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_text_byte            (i_text_byte),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_key_start            (o_key_start),
        .o_key_length           (o_key_length),
        .o_value_start          (o_value_start),
        .o_value_length         (o_value_length),
        .o_value_trimmed_length (o_value_trimmed_length)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic bit blank_char(input ikvt_pkg::t_char c);
        return (c == ikvt_pkg::CH_SPACE) || (c == ikvt_pkg::CH_TAB) ||
               (c == ikvt_pkg::CH_VT) || (c == ikvt_pkg::CH_FF);
    endfunction

    function automatic bit white_char(input ikvt_pkg::t_char c);
        return blank_char(c) || (c == ikvt_pkg::CH_CR) || (c == ikvt_pkg::CH_LF);
    endfunction

    function automatic bit ident_head(input ikvt_pkg::t_char c);
        return (c == ikvt_pkg::CH_UNDER) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit value_end(input ikvt_pkg::t_char c);
        return (c == ikvt_pkg::CH_NUL) || (c == ikvt_pkg::CH_SEMI) ||
               (c == ikvt_pkg::CH_CR) || (c == ikvt_pkg::CH_LF);
    endfunction

    function automatic ikvt_pkg::t_pos bump(input ikvt_pkg::t_pos v);
        return (v == ikvt_pkg::POS_MAX) ? v : v + 1'b1;
    endfunction

    function void end_or_skip(input ikvt_pkg::t_char c);
        scan_state = ((c == ikvt_pkg::CH_NUL) || (c == ikvt_pkg::CH_CR) ||
                      (c == ikvt_pkg::CH_LF)) ? ikvt_pkg::MODE_JUNK
                                              : ikvt_pkg::MODE_LINE_SKIP;
    endfunction

    function void scan_between(input ikvt_pkg::t_char c, input ikvt_pkg::t_pos at);
        if ((c == ikvt_pkg::CH_NUL) || white_char(c)) begin
            scan_state = ikvt_pkg::MODE_JUNK;
        end else if (ident_head(c)) begin
            cur_key_start = at;
            cur_key_len = ikvt_pkg::t_pos'(1);
            scan_state = ikvt_pkg::MODE_KEY;
        end else begin
            scan_state = ikvt_pkg::MODE_LINE_SKIP;
        end
    endfunction

    // Advances the line scanner by one byte; returns 1 when the byte closes an entry.
    function automatic bit scan_byte(input ikvt_pkg::t_char c,
                                     output ikvt_pkg::t_result entry);
        ikvt_pkg::t_pos at;
        bit             closed;
        at = next_offset;
        closed = 1'b0;
        entry = '0;
        case (scan_state)
            ikvt_pkg::MODE_KEY: begin
                if (ident_head(c) || (c >= "0" && c <= "9")) begin
                    cur_key_len = bump(cur_key_len);
                end else if (blank_char(c)) begin
                    scan_state = ikvt_pkg::MODE_BEFORE_EQ;
                end else if (c == ikvt_pkg::CH_EQ) begin
                    scan_state = ikvt_pkg::MODE_AFTER_EQ;
                end else begin
                    end_or_skip(c);
                end
            end
            ikvt_pkg::MODE_BEFORE_EQ: begin
                if (c == ikvt_pkg::CH_EQ) begin
                    scan_state = ikvt_pkg::MODE_AFTER_EQ;
                end else if (!blank_char(c)) begin
                    end_or_skip(c);
                end
            end
            ikvt_pkg::MODE_AFTER_EQ: begin
                if (value_end(c)) begin
                    scan_between(c, at);
                end else if (!blank_char(c)) begin
                    cur_val_start = at;
                    cur_val_len = ikvt_pkg::t_pos'(1);
                    cur_trim_len = ikvt_pkg::t_pos'(1);
                    scan_state = ikvt_pkg::MODE_VALUE;
                end
            end
            ikvt_pkg::MODE_VALUE: begin
                if (value_end(c)) begin
                    entry = {ikvt_pkg::t_field'(cur_key_start),
                             ikvt_pkg::t_field'(cur_key_len),
                             ikvt_pkg::t_field'(cur_val_start),
                             ikvt_pkg::t_field'(cur_val_len),
                             ikvt_pkg::t_field'(cur_trim_len)};
                    closed = 1'b1;
                    scan_between(c, at);
                end else begin
                    cur_val_len = bump(cur_val_len);
                    if (!white_char(c)) begin
                        cur_trim_len = cur_val_len;
                    end
                end
            end
            ikvt_pkg::MODE_LINE_SKIP: begin
                end_or_skip(c);
            end
            default: begin
                scan_between(c, at);
            end
        endcase
        if (c == ikvt_pkg::CH_NUL) begin
            scan_state = ikvt_pkg::MODE_JUNK;
            next_offset = '0;
        end else begin
            next_offset = bump(at);
        end
        return closed;
    endfunction

    function void push_text(input ikvt_pkg::t_char c);
        t_text_item item;
        item.text = c;
        item.fixed = 1'b0;
        item.want = '0;
        text_stream.push_back(item);
    endfunction

    function automatic ikvt_pkg::t_char ident_char(input bit allow_digit);
        int r;
        r = $urandom_range(0, allow_digit ? 62 : 52);
        if (r == 0) begin
            return ikvt_pkg::CH_UNDER;
        end else if (r <= 26) begin
            return ikvt_pkg::t_char'("A" + r - 1);
        end else if (r <= 52) begin
            return ikvt_pkg::t_char'("a" + r - 27);
        end
        return ikvt_pkg::t_char'("0" + r - 53);
    endfunction

    function automatic ikvt_pkg::t_char value_char();
        ikvt_pkg::t_char c;
        do begin
            c = ikvt_pkg::t_char'($urandom_range(1, 255));
        end while ((c == ikvt_pkg::CH_SEMI) || (c == ikvt_pkg::CH_CR) ||
                   (c == ikvt_pkg::CH_LF));
        return c;
    endfunction

    function automatic ikvt_pkg::t_char blank_pick();
        return blank_set[2'($urandom_range(0, 3))];
    endfunction

    function void add_random_line();
        int kind;
        kind = $urandom_range(0, 99);
        repeat ($urandom_range(0, 2)) begin
            push_text(($urandom_range(0, 5) == 0) ? ikvt_pkg::CH_LF : blank_pick());
        end
        if (kind < 78) begin
            push_text(ident_char(1'b0));
            repeat ($urandom_range(0, 5)) push_text(ident_char(1'b1));
            if ($urandom_range(0, 9) == 0) begin
                push_text(ikvt_pkg::t_char'($urandom_range(1, 255)));
            end
            repeat ($urandom_range(0, 2)) push_text(blank_pick());
            push_text(ikvt_pkg::CH_EQ);
            repeat ($urandom_range(0, 2)) push_text(blank_pick());
            if (kind < 70) begin
                repeat ($urandom_range(1, 8)) push_text(value_char());
                if ($urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(1, 3)) push_text(blank_pick());
                end
            end
            case ($urandom_range(0, 3))
                0: begin
                    push_text(ikvt_pkg::CH_SEMI);
                    repeat ($urandom_range(0, 6)) push_text(value_char());
                    push_text(ikvt_pkg::CH_LF);
                end
                1: push_text(ikvt_pkg::CH_CR);
                2: push_text(ikvt_pkg::CH_LF);
                default: push_text(ikvt_pkg::CH_NUL);
            endcase
        end else if (kind < 86) begin
            push_text(ikvt_pkg::CH_SEMI);
            repeat ($urandom_range(0, 10)) push_text(value_char());
            push_text(ikvt_pkg::CH_LF);
        end else if (kind < 96) begin
            repeat ($urandom_range(1, 12)) begin
                push_text(ikvt_pkg::t_char'($urandom_range(0, 255)));
            end
            push_text(ikvt_pkg::CH_LF);
        end else begin
            push_text(ikvt_pkg::CH_NUL);
        end
    endfunction

    function void build_text();
        int mark;
        foreach (dir_rows[i]) begin
            text_stream.push_back(dir_rows[i]);
        end
        mark = text_stream.size();
        while (text_stream.size() - mark < 1500) begin
            add_random_line();
        end
    endfunction

    task automatic check_field(input string name, input ikvt_pkg::t_field want,
                               input ikvt_pkg::t_field got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : entry_check
        ikvt_pkg::t_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pending_entries.size() == 0) begin
                $error("unexpected entry: key_start %0d, value_start %0d",
                       o_key_start, o_value_start);
                fail_count++;
            end else begin
                want = pending_entries.pop_front();
                check_field("key_start", want.key_start, o_key_start);
                check_field("key_length", want.key_length, o_key_length);
                check_field("value_start", want.value_start, o_value_start);
                check_field("value_length", want.value_length, o_value_length);
                check_field("value_trimmed_length", want.value_trimmed_length,
                            o_value_trimmed_length);
                entries_checked++;
            end
        end
    end

    initial begin : receiver
        int  window_left;
        int  ready_pct;
        bit  hold_done;
        window_left = 0;
        ready_pct = 100;
        hold_done = 1'b0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            // One long hold-off while the sender keeps going, so the block backs up.
            if (!hold_done && entries_checked >= 20) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_done = 1'b1;
            end
            if (window_left == 0) begin
                window_left = $urandom_range(20, 80);
                case ($urandom_range(0, 4))
                    0, 1: ready_pct = 100;
                    2: ready_pct = 80;
                    3: ready_pct = 50;
                    default: ready_pct = 15;
                endcase
            end
            window_left--;
            i_ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    initial begin : sender
        t_text_item        item;
        ikvt_pkg::t_result predicted;
        bit                closed;
        int                burst_left;
        int                gap;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_text_byte <= '0;
        build_text();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        burst_left = $urandom_range(1, 40);
        while (text_stream.size() != 0) begin
            item = text_stream.pop_front();
            i_valid <= 1'b1;
            i_text_byte <= item.text;
            do @(posedge i_clk); while (o_ready !== 1'b1);
            closed = scan_byte(item.text, predicted);
            if (item.fixed) begin
                pending_entries.push_back(item.want);
            end else if (closed) begin
                pending_entries.push_back(predicted);
            end
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                if (gap != 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        i_valid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ini_key_value_tokenizer test passed");
        end else begin
            $display("ini_key_value_tokenizer test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #100_000_000;
        $display("ini_key_value_tokenizer test failed");
        $finish;
    end

endmodule
